### rtl/hsv_pkg.sv
`timescale 1ns / 1ps

package hsv_pkg;

  localparam int unsigned HUE_W  = 10;
  localparam int unsigned PCT_W  = 7;
  localparam int unsigned CH_W   = 8;

  localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;
  localparam logic [CH_W-1:0]  CH_MAX  = 8'hff;

  // hue sector codes, named by the channel that ramps
  localparam logic [2:0] SEC_G_UP   = 3'd0;
  localparam logic [2:0] SEC_R_DOWN = 3'd1;
  localparam logic [2:0] SEC_B_UP   = 3'd2;
  localparam logic [2:0] SEC_G_DOWN = 3'd3;
  localparam logic [2:0] SEC_R_UP   = 3'd4;
  localparam logic [2:0] SEC_B_DOWN = 3'd5;

  // floor(x / 100) for x up to 25500, by reciprocal 41944 / 2^22 (exact below 43690)
  function automatic logic [CH_W-1:0] div100(input logic [14:0] x);
    logic [30:0] p;
    p = {16'd0, x} * 31'd41944;
    return p[29:22];
  endfunction

  // floor(y / 255) for y up to 255 * 255
  function automatic logic [CH_W-1:0] div255(input logic [15:0] y);
    logic [16:0] t;
    t = {1'b0, y} + {9'd0, y[15:8]} + 17'd1;
    return t[15:8];
  endfunction

endpackage

### rtl/hsv_to_rgb_converter_top.sv
`timescale 1ns / 1ps
// Channel  Handshake           Payload
// in       in_valid/in_ready   hue[9:0], saturation[6:0], brightness[6:0]
// out      out_valid/out_ready red[7:0], green[7:0], blue[7:0]
//
// Six register stages: one transaction per clock while the output is not stalled.
// Stage split: hue wrap/clamp, sector + high, ramps + low product,
// low, channel products, divide by 255 + offset into output register.
// rst (synchronous) clears the stage valid bits only.
// A stall at the output freezes every stage; nothing is dropped or repeated.
module hsv_to_rgb_converter_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [9:0] hue,
  input  logic [6:0] saturation,
  input  logic [6:0] brightness,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue
);

  logic advance;
  logic v1, v2, v3, v4, v5;

  // stage 1
  logic [8:0] h1;
  logic [6:0] s1, b1;
  // stage 2
  logic [2:0] sec2;
  logic [5:0] d2;
  logic [7:0] hi2;
  logic [6:0] s2;
  // stage 3
  logic [7:0] r3, g3, b3, hi3;
  logic [14:0] lp3;
  // stage 4
  logic [7:0] r4, g4, b4, hi4, lo4;
  // stage 5
  logic [15:0] ry5, gy5, by5;
  logic [7:0] lo5;

  // comb
  logic [8:0] h_wrap;
  logic [6:0] s_clamp, b_clamp;
  logic [2:0] sec_n;
  logic [8:0] d_n;
  logic [14:0] bx;
  logic [9:0] up_t, dn_t;
  logic [7:0] rise_v, fall_v;
  logic [7:0] diff4;

  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  always_comb begin
    if (hue >= 10'd720) begin
      h_wrap = 9'(hue - 10'd720);
    end else if (hue >= 10'd360) begin
      h_wrap = 9'(hue - 10'd360);
    end else begin
      h_wrap = hue[8:0];
    end
    s_clamp = (saturation > hsv_pkg::PCT_MAX) ? hsv_pkg::PCT_MAX : saturation;
    b_clamp = (brightness > hsv_pkg::PCT_MAX) ? hsv_pkg::PCT_MAX : brightness;
  end

  // inclusive upper bounds: the lower sector takes the border
  always_comb begin
    if (h1 <= 9'd60) begin
      sec_n = hsv_pkg::SEC_G_UP;   d_n = h1;
    end else if (h1 <= 9'd120) begin
      sec_n = hsv_pkg::SEC_R_DOWN; d_n = h1 - 9'd60;
    end else if (h1 <= 9'd180) begin
      sec_n = hsv_pkg::SEC_B_UP;   d_n = h1 - 9'd120;
    end else if (h1 <= 9'd240) begin
      sec_n = hsv_pkg::SEC_G_DOWN; d_n = h1 - 9'd180;
    end else if (h1 <= 9'd300) begin
      sec_n = hsv_pkg::SEC_R_UP;   d_n = h1 - 9'd240;
    end else begin
      sec_n = hsv_pkg::SEC_B_DOWN; d_n = h1 - 9'd300;
    end
    bx = {b1, 8'd0} - {8'd0, b1};
  end

  // 255/60 = 17/4
  always_comb begin
    up_t   = {4'd0, d2} * 10'd17;
    dn_t   = up_t + 10'd3;
    rise_v = up_t[9:2];
    fall_v = hsv_pkg::CH_MAX - dn_t[9:2];
  end

  assign diff4 = hi4 - lo4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v1 <= in_valid;
      v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4;
      out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      h1 <= h_wrap;
      s1 <= s_clamp;
      b1 <= b_clamp;

      sec2 <= sec_n;
      d2   <= d_n[5:0];
      hi2  <= hsv_pkg::div100(bx);
      s2   <= s1;

      unique case (sec2)
        hsv_pkg::SEC_G_UP: begin
          r3 <= hsv_pkg::CH_MAX; g3 <= rise_v; b3 <= 8'd0;
        end
        hsv_pkg::SEC_R_DOWN: begin
          r3 <= fall_v; g3 <= hsv_pkg::CH_MAX; b3 <= 8'd0;
        end
        hsv_pkg::SEC_B_UP: begin
          r3 <= 8'd0; g3 <= hsv_pkg::CH_MAX; b3 <= rise_v;
        end
        hsv_pkg::SEC_G_DOWN: begin
          r3 <= 8'd0; g3 <= fall_v; b3 <= hsv_pkg::CH_MAX;
        end
        hsv_pkg::SEC_R_UP: begin
          r3 <= rise_v; g3 <= 8'd0; b3 <= hsv_pkg::CH_MAX;
        end
        default: begin
          r3 <= hsv_pkg::CH_MAX; g3 <= 8'd0; b3 <= fall_v;
        end
      endcase
      hi3 <= hi2;
      lp3 <= {7'd0, hi2} * {8'd0, hsv_pkg::PCT_MAX - s2};

      r4  <= r3; g4 <= g3; b4 <= b3;
      hi4 <= hi3;
      lo4 <= hsv_pkg::div100(lp3);

      ry5 <= {8'd0, diff4} * {8'd0, r4};
      gy5 <= {8'd0, diff4} * {8'd0, g4};
      by5 <= {8'd0, diff4} * {8'd0, b4};
      lo5 <= lo4;

      red   <= lo5 + hsv_pkg::div255(ry5);
      green <= lo5 + hsv_pkg::div255(gy5);
      blue  <= lo5 + hsv_pkg::div255(by5);
    end
  end

  a_hue_wrapped: assert property (@(posedge clk) disable iff (rst)
    v1 |-> (h1 < 9'd360))
    else $error("wrapped hue out of range");

  a_sector_extremes: assert property (@(posedge clk) disable iff (rst)
    v3 |-> ((r3 == 8'hff || g3 == 8'hff || b3 == 8'hff) &&
            (r3 == 8'd0 || g3 == 8'd0 || b3 == 8'd0)))
    else $error("sector lacks a full and an empty channel");

  a_low_le_high: assert property (@(posedge clk) disable iff (rst)
    v4 |-> (lo4 <= hi4))
    else $error("low limit above high limit");

  a_stall_freezes: assert property (@(posedge clk) disable iff (rst)
    !advance |=> ($stable(v5) && $stable(lo5) && $stable(ry5)))
    else $error("pipeline moved during stall");

endmodule

### dv/hsv_to_rgb_converter_checker.sv
`timescale 1ns / 1ps

module hsv_to_rgb_converter_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [9:0] hue,
  input  logic [6:0] saturation,
  input  logic [6:0] brightness,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  output int         fail_count,
  output int         pending
);

  localparam int unsigned HUE_PERIOD = 360;
  localparam int unsigned SECTOR_DEG = 60;

  typedef struct packed {
    logic [hsv_pkg::HUE_W-1:0] hue;
    logic [hsv_pkg::PCT_W-1:0] sat;
    logic [hsv_pkg::PCT_W-1:0] bri;
    logic [hsv_pkg::CH_W-1:0]  red;
    logic [hsv_pkg::CH_W-1:0]  green;
    logic [hsv_pkg::CH_W-1:0]  blue;
  } pixel_t;

  pixel_t rgb_expected_q[$];

  function automatic int unsigned ramp_up(input int unsigned d);
    return (hsv_pkg::CH_MAX * d) / SECTOR_DEG;
  endfunction

  // falling edge rounds the offset up, so a border lands on the same color
  function automatic int unsigned ramp_down(input int unsigned d);
    return hsv_pkg::CH_MAX - (hsv_pkg::CH_MAX * d + SECTOR_DEG - 1) / SECTOR_DEG;
  endfunction

  function automatic logic [hsv_pkg::CH_W-1:0] span_map(input int unsigned c,
                                                        input int unsigned lo,
                                                        input int unsigned hi);
    return hsv_pkg::CH_W'(lo + ((hi - lo) * c) / hsv_pkg::CH_MAX);
  endfunction

  function automatic pixel_t predict_rgb(input logic [hsv_pkg::HUE_W-1:0] h_in,
                                         input logic [hsv_pkg::PCT_W-1:0] s_in,
                                         input logic [hsv_pkg::PCT_W-1:0] v_in);
    int unsigned h, s, v, hi, lo, r, g, b;
    logic [2:0]  sector;
    pixel_t      px;
    h = h_in % HUE_PERIOD;
    s = (s_in > hsv_pkg::PCT_MAX) ? hsv_pkg::PCT_MAX : s_in;
    v = (v_in > hsv_pkg::PCT_MAX) ? hsv_pkg::PCT_MAX : v_in;
    hi = (hsv_pkg::CH_MAX * v) / hsv_pkg::PCT_MAX;
    lo = (hi * (hsv_pkg::PCT_MAX - s)) / hsv_pkg::PCT_MAX;
    // inclusive upper bounds: a border hue belongs to the lower sector
    if (h <= 60)       sector = hsv_pkg::SEC_G_UP;
    else if (h <= 120) sector = hsv_pkg::SEC_R_DOWN;
    else if (h <= 180) sector = hsv_pkg::SEC_B_UP;
    else if (h <= 240) sector = hsv_pkg::SEC_G_DOWN;
    else if (h <= 300) sector = hsv_pkg::SEC_R_UP;
    else               sector = hsv_pkg::SEC_B_DOWN;
    case (sector)
      hsv_pkg::SEC_G_UP: begin
        r = hsv_pkg::CH_MAX; g = ramp_up(h); b = 0;
      end
      hsv_pkg::SEC_R_DOWN: begin
        r = ramp_down(h - 60); g = hsv_pkg::CH_MAX; b = 0;
      end
      hsv_pkg::SEC_B_UP: begin
        r = 0; g = hsv_pkg::CH_MAX; b = ramp_up(h - 120);
      end
      hsv_pkg::SEC_G_DOWN: begin
        r = 0; g = ramp_down(h - 180); b = hsv_pkg::CH_MAX;
      end
      hsv_pkg::SEC_R_UP: begin
        r = ramp_up(h - 240); g = 0; b = hsv_pkg::CH_MAX;
      end
      default: begin
        r = hsv_pkg::CH_MAX; g = 0; b = ramp_down(h - 300);
      end
    endcase
    px.hue   = h_in;
    px.sat   = s_in;
    px.bri   = v_in;
    px.red   = span_map(r, lo, hi);
    px.green = span_map(g, lo, hi);
    px.blue  = span_map(b, lo, hi);
    return px;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin : monitor
    pixel_t want;
    if (rst) begin
      fail_count = 0;
      rgb_expected_q.delete();
      pending <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (rgb_expected_q.size() == 0) begin
          report_mismatch($sformatf("unexpected output transaction rgb=%0d/%0d/%0d",
                                    red, green, blue));
        end else begin
          want = rgb_expected_q.pop_front();
          if (red !== want.red)
            report_mismatch($sformatf("red got %0d exp %0d (h=%0d s=%0d v=%0d)",
                                      red, want.red, want.hue, want.sat, want.bri));
          if (green !== want.green)
            report_mismatch($sformatf("green got %0d exp %0d (h=%0d s=%0d v=%0d)",
                                      green, want.green, want.hue, want.sat, want.bri));
          if (blue !== want.blue)
            report_mismatch($sformatf("blue got %0d exp %0d (h=%0d s=%0d v=%0d)",
                                      blue, want.blue, want.hue, want.sat, want.bri));
        end
      end
      if (in_valid && in_ready)
        rgb_expected_q.push_back(predict_rgb(hue, saturation, brightness));
      pending <= rgb_expected_q.size();
    end
  end

endmodule

### dv/tb_hsv_to_rgb_converter_top.sv
`timescale 1ns / 1ps

module tb_hsv_to_rgb_converter_top;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_PER_PHASE = 125;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [9:0] hue;
  logic [6:0] saturation;
  logic [6:0] brightness;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  int fail_count;
  int pending;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int cycle_count    = 0;

  hsv_to_rgb_converter_top u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .red        (red),
    .green      (green),
    .blue       (blue)
  );

  hsv_to_rgb_converter_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= (recv_stall_pct == 0) ? 1'b1 : ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // present one pixel, hold it until the transaction completes
  task automatic push_pixel(input logic [9:0] h, input logic [6:0] s, input logic [6:0] v);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    hue        <= h;
    saturation <= s;
    brightness <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [6:0] pick_pct();
    case ($urandom_range(7))
      0:       return 7'd0;
      1:       return 7'd100;
      2:       return 7'($urandom_range(101, 127));
      default: return 7'($urandom_range(127));
    endcase
  endfunction

  task automatic push_random_pixel();
    logic [9:0] h;
    // a quarter of the hues sit on or next to a sector border, some past 360
    if ($urandom_range(3) == 0)
      h = 10'(60 * $urandom_range(1, 12) + $urandom_range(2) - 1);
    else
      h = 10'($urandom_range(1023));
    push_pixel(h, pick_pct(), pick_pct());
  endtask

  initial begin
    int send_pcts [4];
    int recv_pcts [4];
    send_pcts  = '{0, 53, 0, 29};
    recv_pcts  = '{0, 0, 53, 29};
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    hue        <= '0;
    saturation <= '0;
    brightness <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // sector borders, wrap, clamps, gray and black
    push_pixel(10'd0,    7'd100, 7'd100);
    push_pixel(10'd1,    7'd100, 7'd100);
    push_pixel(10'd59,   7'd100, 7'd100);
    push_pixel(10'd60,   7'd100, 7'd100);
    push_pixel(10'd61,   7'd100, 7'd100);
    push_pixel(10'd120,  7'd100, 7'd100);
    push_pixel(10'd180,  7'd100, 7'd100);
    push_pixel(10'd240,  7'd100, 7'd100);
    push_pixel(10'd299,  7'd100, 7'd100);
    push_pixel(10'd300,  7'd100, 7'd100);
    push_pixel(10'd301,  7'd100, 7'd100);
    push_pixel(10'd359,  7'd100, 7'd100);
    push_pixel(10'd360,  7'd100, 7'd100);
    push_pixel(10'd719,  7'd100, 7'd100);
    push_pixel(10'd720,  7'd100, 7'd100);
    push_pixel(10'd1023, 7'd100, 7'd100);
    push_pixel(10'd30,   7'd0,   7'd100);
    push_pixel(10'd30,   7'd100, 7'd0);
    push_pixel(10'd90,   7'd127, 7'd127);
    push_pixel(10'd150,  7'd101, 7'd101);
    push_pixel(10'd210,  7'd50,  7'd50);
    push_pixel(10'd270,  7'd99,  7'd1);
    push_pixel(10'd330,  7'd1,   7'd99);
    push_pixel(10'd0,    7'd0,   7'd0);

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = send_pcts[p];
      recv_stall_pct = recv_pcts[p];
      repeat (RANDOM_PER_PHASE) push_random_pixel();
    end
    in_valid <= 1'b0;

    // let the last accepted transaction reach the checker's count
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (fail_count == 0 && pending == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

### files.f
rtl/hsv_pkg.sv
rtl/hsv_to_rgb_converter_top.sv
dv/hsv_to_rgb_converter_checker.sv
dv/tb_hsv_to_rgb_converter_top.sv
